// ----- hdl/mwc_random_with_range_defines.svh -----
// Assertion macros shared by the random number source.
`ifndef MWC_RANDOM_WITH_RANGE_DEFINES_SVH
`define MWC_RANDOM_WITH_RANGE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MWCR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mwcr check failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define MWCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mwcr check failed: next-cycle implication");

`endif

// ----- hdl/mwcr_pkg.sv -----
// Constants and interface types of the random number source.
package mwcr_pkg;

    localparam int DATA_W = 32;
    localparam int HALF_W = DATA_W / 2;
    localparam int CNT_W  = $clog2(DATA_W);
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam logic [HALF_W-1:0] MUL_Z = 16'd36969;
    localparam logic [HALF_W-1:0] MUL_W = 16'd18000;

    localparam logic [DATA_W-1:0] RESET_W = 32'd521288629;
    localparam logic [DATA_W-1:0] RESET_Z = 32'd362436069;

    localparam logic [IDX_W-1:0] REG_SEED_W       = 3'd0;
    localparam logic [IDX_W-1:0] REG_SEED_Z       = 3'd1;
    localparam logic [IDX_W-1:0] REG_RANGE_ENABLE = 3'd2;
    localparam logic [IDX_W-1:0] REG_RANGE_LOW    = 3'd3;
    localparam logic [IDX_W-1:0] REG_RANGE_HIGH   = 3'd4;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic              busy;
        logic [DATA_W-1:0] rem;
    } div_stat_t;

endpackage

// ----- hdl/mwcr_gen.sv -----
// Pair of 16-bit multiply-with-carry generators with optional reseed.
module mwcr_gen (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic                        restart,
    input  logic [mwcr_pkg::DATA_W-1:0] seed_w,
    input  logic [mwcr_pkg::DATA_W-1:0] seed_z,
    output logic [mwcr_pkg::DATA_W-1:0] gen_w,
    output logic [mwcr_pkg::DATA_W-1:0] gen_z
);

    logic [mwcr_pkg::DATA_W-1:0] gen_w_reg, gen_w_next;
    logic [mwcr_pkg::DATA_W-1:0] gen_z_reg, gen_z_next;
    logic [mwcr_pkg::DATA_W-1:0] src_w, src_z;

    always_comb begin
        src_w = (restart && (seed_w != '0)) ? seed_w : gen_w_reg;
        src_z = (restart && (seed_z != '0)) ? seed_z : gen_z_reg;
        gen_w_next = {{mwcr_pkg::HALF_W{1'b0}}, mwcr_pkg::MUL_W}
                   * {{mwcr_pkg::HALF_W{1'b0}}, src_w[mwcr_pkg::HALF_W-1:0]}
                   + {{mwcr_pkg::HALF_W{1'b0}}, src_w[mwcr_pkg::DATA_W-1:mwcr_pkg::HALF_W]};
        gen_z_next = {{mwcr_pkg::HALF_W{1'b0}}, mwcr_pkg::MUL_Z}
                   * {{mwcr_pkg::HALF_W{1'b0}}, src_z[mwcr_pkg::HALF_W-1:0]}
                   + {{mwcr_pkg::HALF_W{1'b0}}, src_z[mwcr_pkg::DATA_W-1:mwcr_pkg::HALF_W]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_w_reg <= mwcr_pkg::RESET_W;
            gen_z_reg <= mwcr_pkg::RESET_Z;
        end else if (step) begin
            gen_w_reg <= gen_w_next;
            gen_z_reg <= gen_z_next;
        end
    end

    assign gen_w = gen_w_reg;
    assign gen_z = gen_z_reg;

endmodule

// ----- hdl/mwcr_div.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module mwcr_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  mwcr_pkg::div_ctrl_t ctrl,
    output mwcr_pkg::div_stat_t stat
);

    logic                        busy_reg, busy_next;
    logic [mwcr_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [mwcr_pkg::DATA_W-1:0] rem_reg, rem_next;
    logic [mwcr_pkg::DATA_W-1:0] quo_reg, quo_next;
    logic [mwcr_pkg::DATA_W-1:0] div_reg, div_next;
    logic [mwcr_pkg::DATA_W:0]   shifted;
    logic [mwcr_pkg::DATA_W:0]   diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[mwcr_pkg::DATA_W-1]};
        diff      = shifted - {1'b0, div_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = ctrl.dividend;
            div_next  = ctrl.divisor;
        end else if (busy_reg) begin
            // The partial remainder stays below the divisor, so 32 bits hold it.
            rem_next = diff[mwcr_pkg::DATA_W] ? shifted[mwcr_pkg::DATA_W-1:0]
                                              : diff[mwcr_pkg::DATA_W-1:0];
            quo_next = {quo_reg[mwcr_pkg::DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.rem  = rem_reg;

endmodule

// ----- hdl/mwc_random_with_range.sv -----
// Top level of the multiply-with-carry random source with range reduction.
//
//  Port group   Direction  Carries
//  s_*          in         one request per transfer: restart
//  m_*          out        one result per transfer: value
//  p*           in/out     APB register access, five 32-bit registers
//
// Each request in range mode goes through these steps: accept and advance, form the raw
// value and span, 32 remainder steps, see the divider finish, then add the low
// bound. With range mode off, or a span of zero, the divider is not used.
// Reset is synchronous and active low; it restores seeds, state and range.
// A waiting result does not block the next request; only the final write
// of the output register waits for the consumer to take the previous one.
`include "mwc_random_with_range_defines.svh"

module mwc_random_with_range (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_restart,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mwcr_pkg::DATA_W-1:0] m_value,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mwcr_pkg::ADDR_W-1:0] paddr,
    input  logic [mwcr_pkg::DATA_W-1:0] pwdata,
    output logic [mwcr_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [mwcr_pkg::DATA_W-1:0] seed_w_reg, seed_z_reg, range_low_reg, range_high_reg;
    logic                        range_enable_reg;
    logic [mwcr_pkg::IDX_W-1:0]  reg_idx;
    logic                        cfg_wr;

    logic                        in_xfer, out_load;
    logic [mwcr_pkg::DATA_W-1:0] gen_w, gen_z;
    logic [mwcr_pkg::DATA_W-1:0] raw, span;
    logic [mwcr_pkg::DATA_W-1:0] raw_reg, raw_next;
    logic                        bypass_reg, bypass_next;
    logic                        m_valid_reg, m_valid_next;
    logic [mwcr_pkg::DATA_W-1:0] m_value_reg, m_value_next;

    mwcr_pkg::div_ctrl_t div_ctrl;
    mwcr_pkg::div_stat_t div_stat;

    // Register access.
    assign pready  = 1'b1;
    assign reg_idx = paddr[mwcr_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_w_reg       <= mwcr_pkg::RESET_W;
            seed_z_reg       <= mwcr_pkg::RESET_Z;
            range_enable_reg <= 1'b0;
            range_low_reg    <= '0;
            range_high_reg   <= '1;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                mwcr_pkg::REG_SEED_W:       seed_w_reg       <= pwdata;
                mwcr_pkg::REG_SEED_Z:       seed_z_reg       <= pwdata;
                mwcr_pkg::REG_RANGE_ENABLE: range_enable_reg <= pwdata[0];
                mwcr_pkg::REG_RANGE_LOW:    range_low_reg    <= pwdata;
                mwcr_pkg::REG_RANGE_HIGH:   range_high_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mwcr_pkg::REG_SEED_W:       prdata = seed_w_reg;
            mwcr_pkg::REG_SEED_Z:       prdata = seed_z_reg;
            mwcr_pkg::REG_RANGE_ENABLE: prdata = {{(mwcr_pkg::DATA_W-1){1'b0}}, range_enable_reg};
            mwcr_pkg::REG_RANGE_LOW:    prdata = range_low_reg;
            mwcr_pkg::REG_RANGE_HIGH:   prdata = range_high_reg;
            default:                    prdata = '0;
        endcase
    end

    // Generators advance at the edge that takes the request.
    assign s_ready = (state_reg == ST_IDLE);
    assign in_xfer = s_valid && s_ready;

    mwcr_gen u_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_xfer),
        .restart (s_restart),
        .seed_w  (seed_w_reg),
        .seed_z  (seed_z_reg),
        .gen_w   (gen_w),
        .gen_z   (gen_z)
    );

    assign raw  = {gen_z[mwcr_pkg::HALF_W-1:0], {mwcr_pkg::HALF_W{1'b0}}} + gen_w;
    assign span = range_high_reg - range_low_reg + 1'b1;

    assign div_ctrl.start    = (state_reg == ST_SETUP) && !bypass_next;
    assign div_ctrl.dividend = raw;
    assign div_ctrl.divisor  = span;

    mwcr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .stat    (div_stat)
    );

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        raw_next     = raw_reg;
        bypass_next  = bypass_reg;
        m_value_next = m_value_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                raw_next    = raw;
                // A span that wraps to zero passes the raw value through.
                bypass_next = !range_enable_reg || (span == '0);
                state_next  = bypass_next ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (!div_stat.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_value_next = bypass_reg ? raw_reg : div_stat.rem + range_low_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            bypass_reg  <= 1'b1;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            bypass_reg  <= bypass_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg     <= raw_next;
        m_value_reg <= m_value_next;
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    `MWCR_ASSERT_NEXT(a_accept_to_setup, in_xfer, state_reg == ST_SETUP)
    `MWCR_ASSERT_SAME(a_div_only_in_div, div_stat.busy, state_reg == ST_DIV)
    `MWCR_ASSERT_NEXT(a_bypass_raw, out_load && bypass_reg, m_valid && (m_value == $past(raw_reg)))

endmodule

// ----- tb/mwcr_draw_checker.sv -----
// Checker for the random number source: mirrors registers and generator, compares every result.
`timescale 1ns / 1ps

module mwcr_draw_checker
    import mwcr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_restart,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [DATA_W-1:0] m_value,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                mismatches,
    output int                outstanding
);

    logic [DATA_W-1:0] seed_w_q;
    logic [DATA_W-1:0] seed_z_q;
    logic              range_on;
    logic [DATA_W-1:0] low_q;
    logic [DATA_W-1:0] high_q;
    logic [DATA_W-1:0] mwc_w;
    logic [DATA_W-1:0] mwc_z;
    logic [DATA_W-1:0] expected_values[$];

    // Advances both generator halves and forms the next number, raw or reduced.
    function automatic logic [DATA_W-1:0] next_value(input logic restart);
        logic [DATA_W-1:0] raw;
        logic [DATA_W-1:0] span;
        if (restart) begin
            // A zero seed leaves its half running where it was.
            if (seed_w_q != '0) mwc_w = seed_w_q;
            if (seed_z_q != '0) mwc_z = seed_z_q;
        end
        mwc_z = MUL_Z * mwc_z[HALF_W-1:0] + mwc_z[DATA_W-1:HALF_W];
        mwc_w = MUL_W * mwc_w[HALF_W-1:0] + mwc_w[DATA_W-1:HALF_W];
        raw   = {mwc_z[HALF_W-1:0], {HALF_W{1'b0}}} + mwc_w;
        span  = high_q - low_q + 1'b1;
        // A span that wraps to zero passes the raw number through.
        if (range_on && span != '0) return raw % span + low_q;
        return raw;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: result mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        logic [DATA_W-1:0] want;
        if (!aresetn) begin
            seed_w_q = RESET_W;
            seed_z_q = RESET_Z;
            range_on = 1'b0;
            low_q    = '0;
            high_q   = '1;
            mwc_w    = RESET_W;
            mwc_z    = RESET_Z;
            expected_values.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_SEED_W:       seed_w_q = pwdata;
                    REG_SEED_Z:       seed_z_q = pwdata;
                    REG_RANGE_ENABLE: range_on = pwdata[0];
                    REG_RANGE_LOW:    low_q    = pwdata;
                    REG_RANGE_HIGH:   high_q   = pwdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_values.size() == 0) begin
                    report_mismatch($sformatf("value %h with no request outstanding", m_value));
                end else begin
                    want = expected_values.pop_front();
                    if (m_value !== want)
                        report_mismatch($sformatf("value %h, expected %h", m_value, want));
                end
            end
            if (s_valid && s_ready) expected_values.push_back(next_value(s_restart));
        end
        outstanding <= expected_values.size();
    end

endmodule

// ----- tb/mwc_random_with_range_tb.sv -----
// Testbench top for the random number source: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module mwc_random_with_range_tb;
    import mwcr_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 5;
    localparam int NUM_REGS        = 5;
    localparam int NUM_PHASES      = 35;
    localparam int DRAWS_PER_PHASE = 50;
    localparam int CALM_PHASES     = 5;
    localparam int HOLD_PHASE      = 3;
    localparam int PAUSE_PHASE     = 6;
    localparam int LONG_HOLD       = 400;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 3000;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_restart = 1'b0;
    logic              m_ready   = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic              s_ready;
    logic              m_valid;
    logic [DATA_W-1:0] m_value;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int   mismatches;
    int   outstanding;
    logic calm         = 1'b0;
    logic hold_req     = 1'b0;
    logic hold_served  = 1'b0;
    int   rx_idle_pct  = 0;
    int   tx_idle_pct  = 0;
    int   stall_left   = 0;
    int   quiet_cycles = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    mwc_random_with_range DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    mwcr_draw_checker draw_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Result side: random stall bursts, plus one long hold that backs up the block.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (hold_req && !hold_served) begin
            hold_served <= 1'b1;
            m_ready     <= 1'b0;
            stall_left  <= LONG_HOLD - 1;
        end else if (!calm && $urandom_range(99) < rx_idle_pct) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(8);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Leaves psel high so that writes can follow back to back; the caller closes the bus.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic apply_setting(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] z,
                                 input logic [DATA_W-1:0] en_word,
                                 input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
        wait_all_results();
        write_reg(REG_SEED_W, w);
        write_reg(REG_SEED_Z, z);
        write_reg(REG_RANGE_ENABLE, en_word);
        write_reg(REG_RANGE_LOW, lo);
        write_reg(REG_RANGE_HIGH, hi);
        // Writes to unmapped indexes must not disturb anything.
        for (int i = NUM_REGS; i < 2 ** IDX_W; i++) write_reg(IDX_W'(i), $urandom());
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Returns at the edge where the request transfer happened, with valid still high.
    task automatic send_draw(input logic restart);
        if (!calm && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(9, 1)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_setting(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] z,
                               input logic [DATA_W-1:0] en_word,
                               input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                               input int draws, input logic restart_first);
        apply_setting(w, z, en_word, lo, hi);
        for (int k = 0; k < draws; k++) send_draw(k == 0 ? restart_first : 1'b0);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(9))
            0, 1:    return '0;
            2:       return '1;
            3:       return $urandom_range(255);
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    task automatic random_setting();
        logic [DATA_W-1:0] en_word;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        int                mode;
        mode       = $urandom_range(5);
        en_word    = $urandom();
        en_word[0] = (mode != 0);
        lo         = pick_word();
        case (mode)
            1: hi = lo + $urandom_range(20);
            2: hi = lo - 1'b1;
            3: begin
                hi = $urandom();
                lo = hi + 32'd2 + $urandom_range(1000);
            end
            5: begin
                lo = '0;
                hi = (32'd1 << $urandom_range(31)) - 1'b1;
            end
            default: hi = pick_word();
        endcase
        apply_setting(pick_word(), pick_word(), en_word, lo, hi);
    endtask

    initial begin
        int restart_pct;
        tx_idle_pct = 30;
        rx_idle_pct <= 30;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset state and reset seeds, then the seed and range corner cases.
        send_draw(1'b0);
        send_draw(1'b0);
        send_draw(1'b1);
        run_setting('0, '0, 32'd0, '0, '1, 2, 1'b1);
        run_setting('1, '1, 32'd0, '0, '1, 1, 1'b1);
        run_setting('0, 32'd1, 32'd0, '0, '1, 1, 1'b1);
        run_setting(RESET_W, RESET_Z, 32'd1, '0, '1, 2, 1'b1);
        run_setting('0, '0, 32'd1, 32'd1, '0, 1, 1'b0);
        run_setting('0, '0, 32'd1, '0, '0, 1, 1'b0);
        run_setting('0, '0, 32'd1, '1, '1, 1, 1'b0);
        run_setting('0, '0, 32'd1, '1, '0, 2, 1'b0);
        run_setting(32'd7, '1, 32'd1, '0, 32'hFFFF_FFFE, 2, 1'b1);
        run_setting('0, '0, 32'd1, 32'd10, 32'd3, 2, 1'b0);
        // Only bit zero of the enable register counts.
        run_setting('0, '0, 32'hFFFF_FFFE, 32'd3, 32'd9, 1, 1'b0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            random_setting();
            calm <= (phase >= NUM_PHASES - CALM_PHASES);
            tx_idle_pct = (phase == HOLD_PHASE) ? 0 : pick_idle_pct();
            rx_idle_pct <= pick_idle_pct();
            if (phase == HOLD_PHASE) hold_req <= 1'b1;
            restart_pct = $urandom_range(30);
            for (int k = 0; k < DRAWS_PER_PHASE; k++) begin
                if (phase == PAUSE_PHASE && k == DRAWS_PER_PHASE / 2) wait_all_results();
                send_draw($urandom_range(99) < restart_pct);
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/mwcr_pkg.sv
hdl/mwcr_gen.sv
hdl/mwcr_div.sv
hdl/mwc_random_with_range.sv
tb/mwcr_draw_checker.sv
tb/mwc_random_with_range_tb.sv
